// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files of the divisor count block.
// Define ASSERT_OFF to compile the assertions out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Concurrent property, disabled while reset is asserted.
`define TDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true at a clock edge.
`define TDC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/tdc_pkg.sv -----
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared constants and types of the triangular divisor count block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdc_pkg;

  localparam int TDC_INDEX_BITS_DEF = 16;
  localparam int TDC_VALUE_W        = 31;
  localparam int TDC_COUNT_W        = 12;
  localparam int TDC_COUNT_MAX      = 4095;
  localparam int TDC_REQ_RESET      = 5;
  localparam int TDC_FIRST_ODD      = 3;

  // Status of the shared divider toward the sequencer
  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdc_div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tdc_div.sv -----
// ----------------------------------------------------------------------------
// tdc_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tdc_div import tdc_pkg::*; #(
  parameter int DVD_W = 2 * TDC_INDEX_BITS_DEF,
  parameter int DVS_W = TDC_INDEX_BITS_DEF + 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output tdc_div_stat_t         stat
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;

  assign shifted = {rem_r, q_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (!diff[DVS_W+1]) begin
        rem_nxt = diff[DVS_W-1:0];
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
      end
      q_nxt    = {q_r[DVD_W-2:0], ~diff[DVS_W+1]};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DVD_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient      = q_r;
  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

  `TDC_ASSERT_NEVER(a_start_busy, clk, rst_n, start && busy_r, "divider started while busy")
  `TDC_ASSERT(a_done_pulse, clk, rst_n, done_r |=> !done_r, "done held longer than a cycle")
  `TDC_ASSERT(a_start_loads, clk, rst_n, (start && !busy_r) |=> (busy_r && step_r == STEP_W'(DVD_W)), "start did not load the step count")

endmodule

`default_nettype wire

// ----- rtl/triangular_divisor_count.sv -----
// ----------------------------------------------------------------------------
// triangular_divisor_count
// Divisor count of the triangular number k(k+1)/2 by trial division.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries the index k. A transfer takes
//   place at a clock edge with in_valid high and in_stall low. in_stall is
//   high from the transfer until the result has moved to the output register.
//   Result channel out_valid / out_stall carries T = k(k+1)/2 (low 31 bits),
//   the divisor count of the full T (saturated at 4095) and the threshold
//   flag. The output register frees the input side: a new index is taken
//   while the previous result still waits under out_stall.
//   cfg_wr_en / cfg_wr_data write the threshold; write only while idle.
// Sequence:
//   out_valid rises after the sequencer has passed S_TRI, S_TWOS, the trial
//   divisions (S_CHK, S_WAIT) and S_FIN; for index zero it goes from S_TRI
//   straight to S_FIN. The next index is taken once the sequencer is back in
//   S_IDLE, which S_FIN holds off while a stalled result still fills the output
//   register. One divider, one quotient bit per cycle, is shared by every trial.
// Reset:
//   Synchronous, active low. Clears the sequencer and the output valid and
//   sets the threshold to 5. There is no memory and no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triangular_divisor_count import tdc_pkg::*; #(
  parameter int INDEX_BITS = TDC_INDEX_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [TDC_COUNT_W-1:0] cfg_wr_data,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [INDEX_BITS-1:0]  in_triangle_index,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [TDC_VALUE_W-1:0]      out_triangular_value,
  output logic [TDC_COUNT_W-1:0]      out_divisor_count,
  output logic                        out_meets_threshold
);

  // full T width, product width, trial divisor width, square width, exponent width
  localparam int TB = 2 * INDEX_BITS;
  localparam int PW = TB + 1;
  localparam int IW = INDEX_BITS + 1;
  localparam int SW = TB + 1;
  localparam int EW = $clog2(TB + 1);
  localparam int CW = TDC_COUNT_W + 1;   // holds the saturation mark 4096

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRI,
    S_TWOS,
    S_CHK,
    S_WAIT,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TDC_COUNT_W-1:0] req_r, req_nxt;
  logic [INDEX_BITS-1:0]  k_r, k_nxt;
  logic [TB-1:0]          n_r, n_nxt;
  logic [TDC_VALUE_W-1:0] tval_r, tval_nxt;
  logic [EW-1:0]          e_r, e_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [IW-1:0]          i_r, i_nxt;
  logic [SW-1:0]          isq_r, isq_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TDC_VALUE_W-1:0] out_tval_r, out_tval_nxt;
  logic [TDC_COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                   out_meets_r, out_meets_nxt;

  // shared divider
  logic                   div_start;
  logic [TB-1:0]          div_dividend;
  logic [TB-1:0]          div_quot;
  tdc_div_stat_t          div_stat;

  // datapath helpers
  logic [IW-1:0]          kp1;
  logic [PW-1:0]          prod;
  logic [TB-1:0]          t_full;
  logic [TB+TDC_VALUE_W-1:0] t_ext;
  logic [EW-1:0]          e1;
  logic [CW+EW-1:0]       cnt_mul;
  logic [CW-1:0]          cnt_sat;
  logic [CW:0]            cnt_dbl;
  logic [CW-1:0]          cnt_fin;
  logic [IW+1:0]          isq_step;

  // T = k(k+1)/2; the product is always even
  assign kp1    = {1'b0, k_r} + IW'(1);
  assign prod   = {{(IW){1'b0}}, k_r} * {{(INDEX_BITS){1'b0}}, kp1};
  assign t_full = prod[PW-1:1];
  assign t_ext  = {{TDC_VALUE_W{1'b0}}, t_full};

  // fold (1 + exponent) into the count, clamp at one past the maximum
  assign e1      = e_r + EW'(1);
  assign cnt_mul = {{EW{1'b0}}, count_r} * {{CW{1'b0}}, e1};
  assign cnt_sat = (cnt_mul > (CW+EW)'(TDC_COUNT_MAX)) ? CW'(TDC_COUNT_MAX + 1)
                                                       : cnt_mul[CW-1:0];

  // a leftover factor above one is prime and doubles the count
  assign cnt_dbl = (n_r > TB'(1)) ? {count_r, 1'b0} : {1'b0, count_r};
  assign cnt_fin = (cnt_dbl > (CW+1)'(TDC_COUNT_MAX)) ? CW'(TDC_COUNT_MAX)
                                                      : cnt_dbl[CW-1:0];

  // (i+2)^2 = i^2 + 4i + 4
  assign isq_step = {i_r, 2'b00} + (IW+2)'(4);

  tdc_div #(
    .DVD_W (TB),
    .DVS_W (IW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (i_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    tval_nxt      = tval_r;
    e_nxt         = e_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    isq_nxt       = isq_r;
    out_valid_nxt = out_valid_r;
    out_tval_nxt  = out_tval_r;
    out_cnt_nxt   = out_cnt_r;
    out_meets_nxt = out_meets_r;
    div_start     = 1'b0;
    div_dividend  = n_r;

    if (cfg_wr_en) begin
      req_nxt = cfg_wr_data;
    end

    // drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt     = in_triangle_index;
          state_nxt = S_TRI;
        end
      end
      S_TRI: begin
        tval_nxt = t_ext[TDC_VALUE_W-1:0];
        n_nxt    = t_full;
        e_nxt    = '0;
        if (t_full == '0) begin
          // index zero: no finite divisor count, report zero
          count_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_TWOS;
        end
      end
      S_TWOS: begin
        if (!n_r[0]) begin
          n_nxt = n_r >> 1;
          e_nxt = e1;
        end else begin
          count_nxt = {{(CW-EW){1'b0}}, e1};
          e_nxt     = '0;
          i_nxt     = IW'(TDC_FIRST_ODD);
          isq_nxt   = SW'(TDC_FIRST_ODD * TDC_FIRST_ODD);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (isq_r <= {1'b0, n_r}) begin
          div_start    = 1'b1;
          div_dividend = n_r;
          state_nxt    = S_WAIT;
        end else begin
          count_nxt = cnt_fin;
          state_nxt = S_FIN;
        end
      end
      S_WAIT: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            // i divides the rest: take the quotient and try i again
            n_nxt        = div_quot;
            e_nxt        = e1;
            div_start    = 1'b1;
            div_dividend = div_quot;
          end else begin
            count_nxt = cnt_sat;
            e_nxt     = '0;
            i_nxt     = i_r + IW'(2);
            isq_nxt   = isq_r + {{(SW-IW-2){1'b0}}, isq_step};
            state_nxt = S_CHK;
          end
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_tval_nxt  = tval_r;
          out_cnt_nxt   = count_r[TDC_COUNT_W-1:0];
          out_meets_nxt = (count_r[TDC_COUNT_W-1:0] >= req_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r       <= TDC_COUNT_W'(TDC_REQ_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    tval_r      <= tval_nxt;
    e_r         <= e_nxt;
    count_r     <= count_nxt;
    i_r         <= i_nxt;
    isq_r       <= isq_nxt;
    out_tval_r  <= out_tval_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_meets_r <= out_meets_nxt;
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_triangular_value = out_tval_r;
  assign out_divisor_count    = out_cnt_r;
  assign out_meets_threshold  = out_meets_r;

  `TDC_ASSERT(a_odd_divisor, clk, rst_n, div_start |-> (i_r[0] && i_r >= IW'(TDC_FIRST_ODD)), "trial divisor not odd")
  `TDC_ASSERT(a_count_range, clk, rst_n, (state_r == S_WAIT) |-> (count_r <= CW'(TDC_COUNT_MAX + 1)), "count above saturation mark")
  `TDC_ASSERT(a_accept_start, clk, rst_n, (in_valid && !in_stall) |=> (state_r == S_TRI), "transfer did not start the product")

endmodule

`default_nettype wire
